/* rtl/core/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants and the slot entry type of the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int SLOT_W = 4;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] OCC_EMPTY   = 2'd0;
  localparam logic [1:0] OCC_USED    = 2'd1;
  localparam logic [1:0] OCC_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]  occ;
    logic [31:0] key;
    logic [15:0] ver;
    logic [31:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing; insert, find and delete.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                   tuser
//  in_      in   key[31:0] version[47:32] data_in[79:48]  cmd[1:0]
//  out_     out  slot[3:0] data_out[35:4]               status[1:0]
//
//  One item at a time. An item probes p slots, p = 1..SLOTS, one after
//  another through the single read port of the slot RAM.
//  An unused command code probes no slot and reports not-found.
//  After reset a clearing pass over all SLOTS slots (16) marks every slot
//  empty; no item is accepted meanwhile.
//  The output register holds a result while the next item is taken in.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key, version, data_in
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // slot, data_out, zero pad
  output logic [1:0]  out_tuser   // status
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_RESP} state_t;

  state_t state_r;

  logic [IDX_W-1:0] clr_r;
  logic [1:0]       cmd_r;
  logic [31:0]      key_r;
  logic [15:0]      ver_r;
  logic [31:0]      din_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] cnt_r;
  logic             free_vld_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [1:0]       res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [31:0]      res_data_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [31:0]      out_data_r;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  entry_t           ent;
  logic             accept;
  logic [IDX_W-1:0] home;
  logic [IDX_W-1:0] nxt_idx;
  logic             is_empty;
  logic             is_used;
  logic             hit;
  logic             last;
  logic             scan_end;
  logic             free_any;
  logic [IDX_W-1:0] free_sel;
  logic [1:0]       fin_status;
  logic [SLOT_W-1:0] fin_slot;
  logic [31:0]      fin_data;

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign home      = IDX_W'(in_tdata[31:0] % SLOTS);

  assign ent      = entry_t'(mem_rdata);
  assign is_empty = (ent.occ == OCC_EMPTY);
  assign is_used  = (ent.occ == OCC_USED);
  assign hit      = is_used && (ent.key == key_r) && (ent.ver == ver_r);
  assign last     = (cnt_r == IDX_W'(SLOTS - 1));
  assign scan_end = hit || is_empty || last;
  assign nxt_idx  = (cur_r == IDX_W'(SLOTS - 1)) ? '0 : cur_r + 1'b1;
  assign free_any = free_vld_r || !is_used;
  assign free_sel = free_vld_r ? free_idx_r : cur_r;

  always_comb begin
    fin_status = ST_NOTFOUND;
    fin_slot   = '0;
    fin_data   = '0;
    if (hit) begin
      fin_slot = SLOT_W'(cur_r);
      case (cmd_r)
        CMD_INSERT: fin_status = ST_DUP;
        CMD_FIND: begin
          fin_status = ST_DONE;
          fin_data   = ent.data;
        end
        default: fin_status = ST_DONE;
      endcase
    end else if (cmd_r == CMD_INSERT) begin
      if (free_any) begin
        fin_status = ST_DONE;
        fin_slot   = SLOT_W'(free_sel);
      end else begin
        fin_status = ST_FULL;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_IDLE: begin
        mem_re    = accept;
        mem_raddr = home;
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = nxt_idx;
        if (scan_end) begin
          if (hit && cmd_r == CMD_DELETE) begin
            mem_we        = 1'b1;
            mem_waddr     = cur_r;
            mem_wdata     = ent;
            mem_wdata.occ = OCC_DELETED;
          end else if (!hit && cmd_r == CMD_INSERT && free_any) begin
            mem_we    = 1'b1;
            mem_waddr = free_sel;
            mem_wdata = '{occ: OCC_USED, key: key_r, ver: ver_r, data: din_r};
          end
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r      <= in_tuser;
            key_r      <= in_tdata[31:0];
            ver_r      <= in_tdata[47:32];
            din_r      <= in_tdata[79:48];
            cur_r      <= home;
            cnt_r      <= '0;
            free_vld_r <= 1'b0;
            if (in_tuser == CMD_INSERT || in_tuser == CMD_FIND ||
                in_tuser == CMD_DELETE) begin
              state_r <= S_SCAN;
            end else begin
              res_status_r <= ST_NOTFOUND;
              res_slot_r   <= '0;
              res_data_r   <= '0;
              state_r      <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (!free_vld_r && !is_used) begin
            free_vld_r <= 1'b1;
            free_idx_r <= cur_r;
          end
          cur_r <= nxt_idx;
          cnt_r <= cnt_r + 1'b1;
          if (scan_end) begin
            res_status_r <= fin_status;
            res_slot_r   <= fin_slot;
            res_data_r   <= fin_data;
            state_r      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_data_r   <= res_data_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_data_r, out_slot_r};

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("item accepted while another is in flight");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || (state_r == S_SCAN && scan_end))
    else $error("slot RAM written outside clear or scan end");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_end && fin_status == ST_FULL) |-> !mem_we)
    else $error("table full but a slot was written");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(state_r == S_RESP))
    else $error("result shown without a finished item");

endmodule
